/* design/smwe_pkg.sv */
// Shared types and constants for the stereo mesh energy accumulator.
package smwe_pkg;

  localparam int unsigned COORD_W = 16;           // Q12.4 coordinate
  localparam int unsigned EDGE_W  = COORD_W + 1;  // signed edge difference
  localparam int unsigned DISP_W  = COORD_W + 2;  // signed displacement difference
  localparam int unsigned NUM_EDGES = 4;
  localparam int unsigned CNT_W   = 2;            // edge index
  localparam int unsigned ERR_W   = 35;           // signed edge error, Q.18
  localparam int unsigned MAG_W   = ERR_W - 1;
  localparam int unsigned RND_W   = 19;           // rounded error magnitude, Q.4
  localparam int unsigned SQ_W    = 2 * RND_W;    // squared error, Q.8
  localparam int unsigned SSUM_W  = SQ_W + 2;     // sum of four squares
  localparam int unsigned TERM_W  = 40;           // one energy term, Q.8
  localparam int unsigned WPROD_W = SSUM_W + COORD_W;
  localparam int unsigned OUT_W   = 48;

  // One classified word handed from the front end to the back end.
  typedef struct packed {
    logic                                is_disp;
    logic                                last;
    logic [NUM_EDGES-1:0][EDGE_W-1:0]    n_edge;   // deformed edges, signed
    logic [NUM_EDGES-1:0][EDGE_W-1:0]    o_edge;   // original edges, signed
    logic [COORD_W-1:0]                  scale;
    logic [COORD_W-1:0]                  weight;
    logic [DISP_W-1:0]                   disp;     // disparity difference, signed
  } item_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SQ   = 6'b000100,
    ST_WGT  = 6'b001000,
    ST_DISP = 6'b010000,
    ST_ACC  = 6'b100000
  } back_state_e;

endpackage

/* design/smwe_if.sv */
// Handshake interfaces for the term input and the energy result output.
interface smwe_term_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] old_v1;
  logic [15:0] old_v2;
  logic [15:0] old_v3;
  logic [15:0] old_v4;
  logic [15:0] new_v1;
  logic [15:0] new_v2;
  logic [15:0] new_v3;
  logic [15:0] new_v4;
  logic [15:0] scale_factor;
  logic [15:0] saliency_weight;
  logic        last;

  modport source (
    output valid, action, old_v1, old_v2, old_v3, old_v4,
           new_v1, new_v2, new_v3, new_v4, scale_factor, saliency_weight, last,
    input  ready
  );
  modport sink (
    input  valid, action, old_v1, old_v2, old_v3, old_v4,
           new_v1, new_v2, new_v3, new_v4, scale_factor, saliency_weight, last,
    output ready
  );
endinterface

interface smwe_result_if;
  logic        valid;
  logic        ready;
  logic [47:0] total_energy;
  logic        saturated;

  modport source (output valid, total_energy, saturated, input ready);
  modport sink   (input valid, total_energy, saturated, output ready);
endinterface

/* design/smwe_front.sv */
// Front end: takes term words, forms edge and disparity differences, queues them.
module smwe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  smwe_term_if.sink          term_i,
  output smwe_pkg::item_t    item_o,
  output logic               item_valid_o,
  input  logic               item_pop_i
);
  import smwe_pkg::*;

  localparam int unsigned DEPTH = 2;

  item_t       item_in;
  item_t       mem_q [DEPTH];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  count_q, count_d;
  logic        push;
  logic        pop;

  function automatic logic [EDGE_W-1:0] edge_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    return {1'b0, a} - {1'b0, b};
  endfunction

  // Edge cycle v1-v2, v2-v4, v4-v3, v3-v1
  always_comb begin
    item_in.is_disp   = term_i.action;
    item_in.last      = term_i.last;
    item_in.n_edge[0] = edge_diff(term_i.new_v1, term_i.new_v2);
    item_in.n_edge[1] = edge_diff(term_i.new_v2, term_i.new_v4);
    item_in.n_edge[2] = edge_diff(term_i.new_v4, term_i.new_v3);
    item_in.n_edge[3] = edge_diff(term_i.new_v3, term_i.new_v1);
    item_in.o_edge[0] = edge_diff(term_i.old_v1, term_i.old_v2);
    item_in.o_edge[1] = edge_diff(term_i.old_v2, term_i.old_v4);
    item_in.o_edge[2] = edge_diff(term_i.old_v4, term_i.old_v3);
    item_in.o_edge[3] = edge_diff(term_i.old_v3, term_i.old_v1);
    item_in.scale     = term_i.scale_factor;
    item_in.weight    = term_i.saliency_weight;
    // (old_l - new_l) - (old_r - new_r)
    item_in.disp      = ({2'b00, term_i.old_v1} - {2'b00, term_i.new_v1})
                      - ({2'b00, term_i.old_v2} - {2'b00, term_i.new_v2});
  end

  assign term_i.ready = (count_q != 2'(DEPTH));
  assign push         = term_i.valid && term_i.ready;
  assign item_valid_o = (count_q != 2'd0);
  assign pop          = item_pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

/* design/smwe_back.sv */
// Back end: edge error sequencer, weighting, saturating accumulator, result register.
module smwe_back #(
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  smwe_pkg::item_t    item_i,
  input  logic               item_valid_i,
  output logic               item_pop_o,
  smwe_result_if.source      result_o
);
  import smwe_pkg::*;

  localparam int unsigned SUM_W =
    ((ACC_WIDTH > OUT_W) ? ACC_WIDTH : OUT_W) + 1;
  localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'({ACC_WIDTH{1'b1}});
  localparam logic [SUM_W-1:0] OUT_MAX = SUM_W'({OUT_W{1'b1}});

  back_state_e            state_q, state_d;
  item_t                  item_q;
  logic [CNT_W-1:0]       cnt_q;
  logic signed [ERR_W-1:0] err_q;
  logic [SSUM_W-1:0]      ssum_q;
  logic [TERM_W-1:0]      term_q;
  logic [ACC_WIDTH-1:0]   acc_q;
  logic                   ovf_q;
  logic                   out_valid_q;
  logic [OUT_W-1:0]       total_q;
  logic                   sat_q;

  logic signed [EDGE_W-1:0]   n_sel;
  logic signed [EDGE_W-1:0]   o_sel;
  logic signed [2*EDGE_W-1:0] os_prod;
  logic signed [ERR_W-1:0]    err_d;
  logic [MAG_W-1:0]           mag;
  logic [MAG_W:0]             mag_rnd;
  logic [RND_W-1:0]           rnd;
  logic [SQ_W-1:0]            sq;
  logic [WPROD_W-1:0]         wprod;
  logic signed [DISP_W-1:0]   disp_s;
  logic [2*DISP_W-1:0]        disp_sq;
  logic [SUM_W-1:0]           acc_sum;
  logic                       acc_ovf;
  logic [ACC_WIDTH-1:0]       acc_new;
  logic                       out_clip;
  logic                       out_free;
  logic                       acc_fire;

  // edge error for the selected edge, Q.18
  assign n_sel   = $signed(item_q.n_edge[cnt_q]);
  assign o_sel   = $signed(item_q.o_edge[cnt_q]);
  assign os_prod = o_sel * $signed({1'b0, item_q.scale});
  assign err_d   = (ERR_W'(n_sel) <<< 14) - ERR_W'(os_prod);

  // round magnitude half away from zero to Q.4, then square
  assign mag     = err_q[ERR_W-1] ? MAG_W'(-err_q) : MAG_W'(err_q);
  assign mag_rnd = {1'b0, mag} + (MAG_W+1)'(8192);
  assign rnd     = mag_rnd[14 +: RND_W];
  assign sq      = rnd * rnd;

  assign wprod   = ssum_q * item_q.weight;
  assign disp_s  = $signed(item_q.disp);
  // widen before the multiply so the full square survives
  assign disp_sq = $unsigned((2*DISP_W)'(disp_s) * (2*DISP_W)'(disp_s));

  // saturating accumulate and output clip
  assign acc_sum  = SUM_W'(acc_q) + SUM_W'(term_q);
  assign acc_ovf  = (acc_sum > ACC_MAX);
  assign acc_new  = acc_ovf ? {ACC_WIDTH{1'b1}} : acc_sum[ACC_WIDTH-1:0];
  assign out_clip = (SUM_W'(acc_new) > OUT_MAX);

  assign out_free   = !out_valid_q || result_o.ready;
  assign acc_fire   = (state_q == ST_ACC) && (!item_q.last || out_free);
  assign item_pop_o = (state_q == ST_IDLE) && item_valid_i;

  assign result_o.valid        = out_valid_q;
  assign result_o.total_energy = total_q;
  assign result_o.saturated    = sat_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (item_valid_i) begin
          state_d = item_i.is_disp ? ST_DISP : ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_SQ;
      ST_SQ:   state_d = (cnt_q == CNT_W'(NUM_EDGES - 1)) ? ST_WGT : ST_MUL;
      ST_WGT:  state_d = ST_ACC;
      ST_DISP: state_d = ST_ACC;
      ST_ACC: begin
        if (acc_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (acc_fire && item_q.last) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (acc_fire) begin
        if (item_q.last) begin
          acc_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          acc_q <= acc_new;
          ovf_q <= ovf_q | acc_ovf;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o) begin
      item_q <= item_i;
      cnt_q  <= '0;
      ssum_q <= '0;
    end
    if (state_q == ST_MUL) begin
      err_q <= err_d;
    end
    if (state_q == ST_SQ) begin
      ssum_q <= ssum_q + SSUM_W'(sq);
      cnt_q  <= cnt_q + CNT_W'(1);
    end
    if (state_q == ST_WGT) begin
      term_q <= TERM_W'((wprod + WPROD_W'(32768)) >> 16);
    end
    if (state_q == ST_DISP) begin
      term_q <= TERM_W'(disp_sq);
    end
    if (acc_fire && item_q.last) begin
      total_q <= out_clip ? {OUT_W{1'b1}} : OUT_W'(acc_new);
      sat_q   <= ovf_q | acc_ovf | out_clip;
    end
  end

  a_last_edge_to_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SQ && cnt_q == CNT_W'(NUM_EDGES - 1)) |=> (state_q == ST_WGT))
    else $error("edge loop did not end after the fourth edge");

  a_last_clears_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_fire && item_q.last) |=> (acc_q == '0 && !ovf_q && out_valid_q))
    else $error("final term did not post a result and clear the sum");

  a_no_pop_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !item_pop_o)
    else $error("queue popped while a term is in flight");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && item_q.last && out_valid_q && !result_o.ready)
      |=> (state_q == ST_ACC))
    else $error("final term retired while the result register was full");

endmodule

/* design/stereo_mesh_warp_energy.sv */
// Top level of the stereo mesh warp energy accumulator.
//
//  port      dir  word contents
//  --------  ---  ----------------------------------------------------------
//  term_i    in   action, old_v1..old_v4, new_v1..new_v4, scale_factor,
//                 saliency_weight, last
//  result_o  out  total_energy (48 b), saturated
//
// Steps: in the back end a quad word goes through pick-up, each edge in turn
//   (MUL, SQ) through the one shared edge error unit, weighting, accumulate; a
//   disparity word: pick-up, DISP, accumulate. The edge loop sets the rate.
// Reset: rst_ni clears the queue, the sequencer, the running sum and flag.
// Stalls: a two-word queue decouples the input from the back end; the result
//   register lets new words queue while a total waits to be taken. Only a
//   word marked last waits on a full result register.
module stereo_mesh_warp_energy #(
  parameter int unsigned ACC_WIDTH = 48
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  smwe_term_if.sink     term_i,
  smwe_result_if.source result_o
);
  import smwe_pkg::*;

  item_t item;
  logic  item_valid;
  logic  item_pop;

  // Front end: differences per edge and per vertex, then a short queue.
  smwe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .term_i       (term_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  // Back end: error squares, weight, saturating sum, result register.
  smwe_back #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .result_o     (result_o)
  );

endmodule
